// ===== sv/compare_timer_three_channel_macros.svh =====
// ----------------------------------------------------------------------------
// compare_timer_three_channel assertion macros
// Small wrappers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COMPARE_TIMER_THREE_CHANNEL_MACROS_SVH
`define COMPARE_TIMER_THREE_CHANNEL_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CTT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared constants, operation codes and word types of the compare timer.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int NUM_CHANNELS   = 3;
    localparam int CH_WIDTH       = 2;
    localparam int OP_WIDTH       = 4;
    localparam int SHIFT_WIDTH    = 4;
    localparam int PRESCALE_WIDTH = 10;
    localparam int MAX_SHIFT      = 10;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [COUNT_WIDTH-1:0] TOP_RESET = 16'hffff;

    // operation codes
    localparam logic [OP_WIDTH-1:0] OP_TICK    = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_ARM_REL = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_ARM_ABS = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DISARM  = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_READ    = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_START   = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_STOP    = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_ZERO    = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_SERVICE = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRESCALE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOP_VALUE      = 2'd1;

    typedef struct packed {
        logic [OP_WIDTH-1:0]    operation;
        logic [CH_WIDTH-1:0]    channel;
        logic [COUNT_WIDTH-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   error;
        logic                   irq_request;
        logic                   served_valid;
        logic [CH_WIDTH-1:0]    served_channel;
    } out_word_t;

    // decoded command strobes, each high only in the cycle the word is processed
    typedef struct packed {
        logic tick;
        logic arm_rel;
        logic arm_abs;
        logic disarm;
        logic start;
        logic stop;
        logic zero;
        logic service;
    } cmd_t;

endpackage

// ===== sv/compare_timer_three_channel.sv =====
// ----------------------------------------------------------------------------
// compare_timer_three_channel
// 16-bit prescaled up-counter with three one-shot compare channels.
// ----------------------------------------------------------------------------
// Takes one word per clock while results are drained, and returns exactly one
// result word for each. A word is captured in an input register, processed
// against the timer state in a single pass and the result lands in an output
// register, where it is held until m_ready takes it, and the next word can
// follow in the very next cycle. While a result waits on m_ready the input
// stage holds at most one more word and then drops s_ready. Configuration writes
// are always ready and should be issued only while no word is in flight.
module compare_timer_three_channel (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ctt_pkg::in_word_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ctt_pkg::out_word_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [ctt_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import ctt_pkg::*;

    `include "compare_timer_three_channel_macros.svh"

    logic                   in_valid_reg;
    logic                   in_valid_next;
    in_word_t               in_word_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_word_t              out_word_reg;
    out_word_t              out_word_next;
    logic [SHIFT_WIDTH-1:0] shift_reg;
    logic [COUNT_WIDTH-1:0] top_reg;
    logic                   fire;
    cmd_t                   cmd;
    logic [COUNT_WIDTH-1:0] count_now;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_after;
    logic                   advance;
    logic                   error;
    logic                   irq_request;
    logic                   served_valid;
    logic [CH_WIDTH-1:0]    served_channel;

    // pipeline moves when the result slot is free or being drained
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    always_comb begin
        cmd = '0;
        if (fire) begin
            unique case (in_word_reg.operation)
                OP_TICK:    cmd.tick    = 1'b1;
                OP_ARM_REL: cmd.arm_rel = 1'b1;
                OP_ARM_ABS: cmd.arm_abs = 1'b1;
                OP_DISARM:  cmd.disarm  = 1'b1;
                OP_START:   cmd.start   = 1'b1;
                OP_STOP:    cmd.stop    = 1'b1;
                OP_ZERO:    cmd.zero    = 1'b1;
                OP_SERVICE: cmd.service = 1'b1;
                default:    cmd         = '0;
            endcase
        end
    end

    ctt_timebase u_timebase (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .prescale_shift (shift_reg),
        .top_value      (top_reg),
        .count_now      (count_now),
        .count_next     (count_next),
        .count_after    (count_after),
        .advance        (advance)
    );

    ctt_channels u_channels (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .channel        (in_word_reg.channel),
        .value          (in_word_reg.value),
        .count_now      (count_now),
        .count_next     (count_next),
        .advance        (advance),
        .error          (error),
        .irq_request    (irq_request),
        .served_valid   (served_valid),
        .served_channel (served_channel)
    );

    always_comb begin
        out_word_next.count          = count_after;
        out_word_next.error          = error;
        out_word_next.irq_request    = irq_request;
        out_word_next.served_valid   = served_valid;
        out_word_next.served_channel = served_channel;
    end

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            shift_reg     <= '0;
            top_reg       <= TOP_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PRESCALE_SHIFT: shift_reg <= cfg_data[SHIFT_WIDTH-1:0];
                    CFG_TOP_VALUE:      top_reg   <= cfg_data[COUNT_WIDTH-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (fire) begin
            out_word_reg <= out_word_next;
        end
    end

    `CTT_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, m_valid, "processed word left no result")
    `CTT_ASSERT_NEXT(a_held_word_kept, aclk, aresetn, in_valid_reg && !fire, in_valid_reg, "held word dropped")
    `CTT_ASSERT_NOW(a_error_not_served, aclk, aresetn, fire && error, !served_valid, "error and service together")
    `CTT_ASSERT_NOW(a_served_in_range, aclk, aresetn, fire && served_valid, served_channel != 2'd3, "served channel out of range")

endmodule

// ===== sv/ctt_timebase.sv =====
// ----------------------------------------------------------------------------
// ctt_timebase
// Prescaler, run flag and wrapping up-counter of the compare timer.
// ----------------------------------------------------------------------------
module ctt_timebase (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ctt_pkg::cmd_t                       cmd,
    input  logic [ctt_pkg::SHIFT_WIDTH-1:0]     prescale_shift,
    input  logic [ctt_pkg::COUNT_WIDTH-1:0]     top_value,
    output logic [ctt_pkg::COUNT_WIDTH-1:0]     count_now,
    output logic [ctt_pkg::COUNT_WIDTH-1:0]     count_next,
    output logic [ctt_pkg::COUNT_WIDTH-1:0]     count_after,
    output logic                                advance
);
    import ctt_pkg::*;

    logic [COUNT_WIDTH-1:0]    counter_reg;
    logic [COUNT_WIDTH-1:0]    counter_next;
    logic [PRESCALE_WIDTH-1:0] prescale_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_next;
    logic                      running_reg;
    logic                      running_next;
    logic [SHIFT_WIDTH-1:0]    shift_eff;
    logic [PRESCALE_WIDTH:0]   limit_wide;
    logic [PRESCALE_WIDTH-1:0] limit;
    logic                      rollover;
    logic                      step;

    assign shift_eff  = (prescale_shift > SHIFT_WIDTH'(MAX_SHIFT)) ?
                        SHIFT_WIDTH'(MAX_SHIFT) : prescale_shift;
    assign limit_wide = ((PRESCALE_WIDTH+1)'(1) << shift_eff) - (PRESCALE_WIDTH+1)'(1);
    assign limit      = limit_wide[PRESCALE_WIDTH-1:0];

    // a lowered prescale can leave the phase above the limit: roll over at once
    assign rollover   = (prescale_reg >= limit);
    assign step       = cmd.tick && running_reg;
    assign advance    = step && rollover;

    assign count_now  = counter_reg;
    assign count_next = (counter_reg == top_value) ? '0 : counter_reg + COUNT_WIDTH'(1);

    always_comb begin
        counter_next  = counter_reg;
        prescale_next = prescale_reg;
        running_next  = running_reg;
        if (step) begin
            prescale_next = rollover ? '0 : prescale_reg + PRESCALE_WIDTH'(1);
        end
        if (advance) begin
            counter_next = count_next;
        end
        if (cmd.zero) begin
            counter_next = '0;
        end
        if (cmd.start) begin
            running_next = 1'b1;
        end
        if (cmd.stop) begin
            running_next = 1'b0;
        end
    end

    assign count_after = counter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg  <= '0;
            prescale_reg <= '0;
            running_reg  <= 1'b0;
        end else begin
            counter_reg  <= counter_next;
            prescale_reg <= prescale_next;
            running_reg  <= running_next;
        end
    end

endmodule

// ===== sv/ctt_channels.sv =====
// ----------------------------------------------------------------------------
// ctt_channels
// Compare values, match flags and enables of the three one-shot channels,
// with arm, disarm and service handling.
// ----------------------------------------------------------------------------
module ctt_channels (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ctt_pkg::cmd_t                   cmd,
    input  logic [ctt_pkg::CH_WIDTH-1:0]    channel,
    input  logic [ctt_pkg::COUNT_WIDTH-1:0] value,
    input  logic [ctt_pkg::COUNT_WIDTH-1:0] count_now,
    input  logic [ctt_pkg::COUNT_WIDTH-1:0] count_next,
    input  logic                            advance,
    output logic                            error,
    output logic                            irq_request,
    output logic                            served_valid,
    output logic [ctt_pkg::CH_WIDTH-1:0]    served_channel
);
    import ctt_pkg::*;

    logic [COUNT_WIDTH-1:0]  compare_reg  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  compare_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] flag_reg;
    logic [NUM_CHANNELS-1:0] flag_next;
    logic [NUM_CHANNELS-1:0] enable_reg;
    logic [NUM_CHANNELS-1:0] enable_next;
    logic [NUM_CHANNELS-1:0] pending;
    logic [COUNT_WIDTH-1:0]  rel_value;
    logic                    valid_ch;
    logic                    arm;
    logic                    sel;

    assign valid_ch  = (channel < CH_WIDTH'(NUM_CHANNELS));
    assign arm       = cmd.arm_rel || cmd.arm_abs;
    assign error     = (arm || cmd.disarm) && !valid_ch;
    assign rel_value = count_now + value - COUNT_WIDTH'(1);
    assign pending   = flag_reg & enable_reg;

    always_comb begin
        served_valid   = 1'b0;
        served_channel = '0;
        flag_next      = flag_reg;
        enable_next    = enable_reg;
        sel            = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            compare_next[i] = compare_reg[i];
        end
        // flags latch on every landing, enabled or not
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (advance && (count_next == compare_reg[i])) begin
                flag_next[i] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            sel = valid_ch && (channel == CH_WIDTH'(i));
            if (arm && sel) begin
                compare_next[i] = cmd.arm_rel ? rel_value : value;
                flag_next[i]    = 1'b0;
                enable_next[i]  = 1'b1;
            end
            if (cmd.disarm && sel) begin
                enable_next[i] = 1'b0;
            end
        end
        // lowest pending channel wins
        if (cmd.service) begin
            for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
                if (pending[i]) begin
                    served_valid   = 1'b1;
                    served_channel = CH_WIDTH'(i);
                end
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (served_valid && (served_channel == CH_WIDTH'(i))) begin
                    flag_next[i]   = 1'b0;
                    enable_next[i] = 1'b0;
                end
            end
        end
    end

    assign irq_request = |(flag_next & enable_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= '0;
            enable_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                compare_reg[i] <= '0;
            end
        end else begin
            flag_reg   <= flag_next;
            enable_reg <= enable_next;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                compare_reg[i] <= compare_next[i];
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-channel compare timer. A shadow copy of
// the timer state predicts every result word. It runs a directed opening, then
// random phases under different prescale and top settings, and one tick run
// that carries the counter above top. The sender idles in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    import ctt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CH_WIDTH-1:0]      CH_INVALID    = 2'd3;
    localparam logic [OP_WIDTH-1:0]      OP_UNUSED_LO  = 4'd9;
    localparam logic [OP_WIDTH-1:0]      OP_UNUSED_HI  = 4'd15;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED_B = 2'd3;

    // shadow of the timer: registers, counter state and the result words owed
    class timer_shadow;
        logic [SHIFT_WIDTH-1:0]    shift_reg;
        logic [COUNT_WIDTH-1:0]    top_reg;
        logic [COUNT_WIDTH-1:0]    counter;
        logic [PRESCALE_WIDTH-1:0] prescale_count;
        bit                        running;
        logic [COUNT_WIDTH-1:0]    compare_value [NUM_CHANNELS];
        logic [NUM_CHANNELS-1:0]   match_flag;
        logic [NUM_CHANNELS-1:0]   channel_enable;
        out_word_t                 owed_words [$];
        int                        mismatches;

        function new();
            shift_reg      = '0;
            top_reg        = TOP_RESET;
            counter        = '0;
            prescale_count = '0;
            running        = 1'b0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) compare_value[ch] = '0;
            match_flag     = '0;
            channel_enable = '0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            if (idx == CFG_PRESCALE_SHIFT) shift_reg = data[SHIFT_WIDTH-1:0];
            else if (idx == CFG_TOP_VALUE) top_reg = data[COUNT_WIDTH-1:0];
        endfunction

        function void tick();
            int eff;
            int limit;
            eff = (shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg;
            limit = (1 << eff) - 1;
            if (!running) return;
            if (prescale_count >= limit) begin
                prescale_count = '0;
                if (counter == top_reg) counter = '0;
                else counter = counter + 1'b1;
                for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                    if (counter == compare_value[ch]) match_flag[ch] = 1'b1;
                end
            end else begin
                prescale_count = prescale_count + 1'b1;
            end
        endfunction

        function void take_word(in_word_t w);
            out_word_t r;
            bit ch_ok;
            logic [NUM_CHANNELS-1:0] pend;
            r = '0;
            ch_ok = (w.channel < NUM_CHANNELS);
            case (w.operation)
                OP_TICK: tick();
                OP_ARM_REL, OP_ARM_ABS: begin
                    if (!ch_ok) begin
                        r.error = 1'b1;
                    end else begin
                        if (w.operation == OP_ARM_REL)
                            compare_value[w.channel] = counter + w.value - 16'd1;
                        else
                            compare_value[w.channel] = w.value;
                        match_flag[w.channel] = 1'b0;
                        channel_enable[w.channel] = 1'b1;
                    end
                end
                OP_DISARM: begin
                    if (!ch_ok) r.error = 1'b1;
                    else channel_enable[w.channel] = 1'b0;
                end
                OP_START: running = 1'b1;
                OP_STOP:  running = 1'b0;
                OP_ZERO:  counter = '0;
                OP_SERVICE: begin
                    pend = match_flag & channel_enable;
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        if (pend[k] && !r.served_valid) begin
                            r.served_valid = 1'b1;
                            r.served_channel = k[CH_WIDTH-1:0];
                            match_flag[k] = 1'b0;
                            channel_enable[k] = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            r.count = counter;
            r.irq_request = |(match_flag & channel_enable);
            owed_words.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: count=%h err=%b irq=%b sv=%b sch=%0d",
                             got.count, got.error, got.irq_request, got.served_valid,
                             got.served_channel);
                return;
            end
            want = owed_words.pop_front();
            if (got.count !== want.count || got.error !== want.error ||
                got.irq_request !== want.irq_request || got.served_valid !== want.served_valid ||
                got.served_channel !== want.served_channel) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch at %0t: expected count=%h err=%b irq=%b sv=%b sch=%0d",
                             $time, want.count, want.error, want.irq_request,
                             want.served_valid, want.served_channel);
                    $display("                   actual count=%h err=%b irq=%b sv=%b sch=%0d",
                             got.count, got.error, got.irq_request, got.served_valid,
                             got.served_channel);
                end
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_word_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_word_t                 m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    timer_shadow shadow;
    int  cycle_count = 0;
    int  burst_left  = 0;
    bit  tx_bursty   = 1'b1;
    bit  rx_steady   = 1'b0;
    int  rx_mode     = 0;
    int  rx_hold     = 0;

    compare_timer_three_channel dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // watch all three handshakes, then pick the next m_ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) shadow.take_word(s_data);
            if (m_valid && m_ready) shadow.check_result(m_data);
            if (cfg_valid && cfg_ready) shadow.write_reg(cfg_index, cfg_data);
        end
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_hold <= $urandom_range(32, 256);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= ~m_ready;
            endcase
        end
    end

    function automatic in_word_t make_word(logic [OP_WIDTH-1:0] op, logic [CH_WIDTH-1:0] ch,
                                           logic [COUNT_WIDTH-1:0] val);
        in_word_t w;
        w.operation = op;
        w.channel   = ch;
        w.value     = val;
        return w;
    endfunction

    // mostly ticks and arms close to the count so compares fire, plus noise
    function automatic in_word_t random_word();
        in_word_t w;
        int pick;
        w.channel = CH_WIDTH'($urandom_range(0, NUM_CHANNELS - 1));
        w.value   = COUNT_WIDTH'($urandom_range(0, 40));
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
            w.operation = OP_TICK;
        end else if (pick < 62) begin
            w.operation = OP_ARM_REL;
        end else if (pick < 68) begin
            w.operation = OP_ARM_ABS;
            w.value = shadow.counter + COUNT_WIDTH'($urandom_range(0, 12));
        end else if (pick < 71) begin
            w.operation = OP_DISARM;
        end else if (pick < 82) begin
            w.operation = OP_SERVICE;
        end else if (pick < 85) begin
            w.operation = OP_READ;
        end else if (pick < 89) begin
            w.operation = OP_START;
        end else if (pick < 91) begin
            w.operation = OP_STOP;
        end else if (pick < 92) begin
            w.operation = OP_ZERO;
        end else begin
            w.operation = OP_WIDTH'($urandom_range(0, 15));
            w.channel   = CH_WIDTH'($urandom_range(0, 3));
            w.value     = COUNT_WIDTH'($urandom);
        end
        if ($urandom_range(0, 19) == 0) w.channel = CH_INVALID;
        if ($urandom_range(0, 9) == 0) w.value = COUNT_WIDTH'($urandom);
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (tx_bursty && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) burst_left--;
    endtask

    // let every owed word drain before touching the registers
    task automatic drain();
        s_valid <= 1'b0;
        while (shadow.owed_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [SHIFT_WIDTH-1:0] shift,
                             input logic [COUNT_WIDTH-1:0] top, input int n_words);
        logic [CFG_DATA_WIDTH-1:0] d;
        d = CFG_DATA_WIDTH'($urandom);
        d[SHIFT_WIDTH-1:0] = shift;
        cfg_write(CFG_PRESCALE_SHIFT, d);
        cfg_write(CFG_TOP_VALUE, top);
        send_word(make_word(OP_START, 2'd0, 16'd0));
        repeat (n_words) send_word(random_word());
    endtask

    // counter runs above top and keeps counting up, landing on a compare there
    task automatic wrap_run();
        cfg_write(CFG_PRESCALE_SHIFT, 16'd0);
        cfg_write(CFG_TOP_VALUE, 16'hffff);
        send_word(make_word(OP_START, 2'd0, 16'd0));
        send_word(make_word(OP_ZERO, 2'd0, 16'd0));
        repeat (60) send_word(make_word(OP_TICK, 2'd0, 16'd0));
        send_word(make_word(OP_ARM_ABS, 2'd0, 16'd90));
        send_word(make_word(OP_ARM_ABS, 2'd1, 16'd5));
        send_word(make_word(OP_ARM_ABS, 2'd2, 16'd40));
        cfg_write(CFG_TOP_VALUE, 16'd40);
        tx_bursty = 1'b0;
        rx_steady = 1'b1;
        repeat (60) send_word(make_word(OP_TICK, 2'd0, 16'd0));
        tx_bursty = 1'b1;
        rx_steady = 1'b0;
        repeat (4) send_word(make_word(OP_SERVICE, 2'd0, 16'd0));
    endtask

    initial begin
        shadow = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening at reset settings
        send_word(make_word(OP_READ, 2'd0, 16'h0000));
        send_word(make_word(OP_TICK, 2'd0, 16'hffff));
        send_word(make_word(OP_ARM_ABS, 2'd0, 16'd3));
        send_word(make_word(OP_ARM_REL, 2'd1, 16'h0000));
        send_word(make_word(OP_ARM_REL, 2'd2, 16'hffff));
        send_word(make_word(OP_ARM_ABS, CH_INVALID, 16'd7));
        send_word(make_word(OP_DISARM, CH_INVALID, 16'd0));
        send_word(make_word(OP_ARM_REL, CH_INVALID, 16'hffff));
        send_word(make_word(OP_START, 2'd0, 16'd0));
        repeat (4) send_word(make_word(OP_TICK, 2'd0, 16'd0));
        send_word(make_word(OP_SERVICE, CH_INVALID, 16'd0));
        send_word(make_word(OP_SERVICE, 2'd0, 16'd0));
        send_word(make_word(OP_DISARM, 2'd1, 16'd0));
        send_word(make_word(OP_ZERO, 2'd0, 16'd0));
        send_word(make_word(OP_STOP, 2'd0, 16'd0));
        send_word(make_word(OP_TICK, 2'd0, 16'd0));
        send_word(make_word(OP_UNUSED_LO, 2'd2, 16'hffff));
        send_word(make_word(OP_UNUSED_HI, CH_INVALID, 16'h5a5a));
        send_word(make_word(OP_ARM_ABS, 2'd0, 16'd0));
        send_word(make_word(OP_START, 2'd0, 16'd0));
        send_word(make_word(OP_TICK, 2'd0, 16'd0));

        cfg_write(CFG_UNMAPPED_A, CFG_DATA_WIDTH'($urandom));
        cfg_write(CFG_UNMAPPED_B, CFG_DATA_WIDTH'($urandom));

        run_phase(4'd0, 16'hffff, 100);
        run_phase(4'd0, 16'd1, 50);
        run_phase(4'd2, 16'd25, 80);
        run_phase(4'd10, 16'hffff, 60);
        // prescaler phase from the slow setting carries into a short limit
        run_phase(4'd1, 16'd17, 60);
        run_phase(4'd15, 16'd300, 50);
        run_phase(4'd0, 16'd0, 40);
        run_phase(4'd3, 16'hffff, 80);
        wrap_run();
        run_phase(4'd0, 16'd9, 70);

        drain();
        repeat (10) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.owed_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/ctt_pkg.sv
sv/ctt_timebase.sv
sv/ctt_channels.sv
sv/compare_timer_three_channel.sv
bench/tb.sv
